[hdl/assert_macros.svh]
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[hdl/rfho_pkg.sv]
// Shared constants, types and helpers of the radial falloff height offset block.
`default_nettype none
package rfho_pkg;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int AXIS_W    = DATA_W;
   localparam int SUM_W     = 2*AXIS_W + 1;
   localparam int ROOT_W    = (SUM_W + 1) / 2;
   localparam int RAD_SQ_W  = 2*ROOT_W;
   localparam int REM_SQ_W  = ROOT_W + 2;
   localparam int RADIUS_W  = 31;
   localparam int DVD_W     = ROOT_W + FRAC_BITS;
   localparam int REM_DV_W  = RADIUS_W + 1;
   localparam int MAG_W     = DATA_W - 1;
   localparam int POLY_DEPTH = 10;
   localparam int SAT_W     = 2*DATA_W + 2;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 3*DATA_W;
   localparam int RSP_W     = ((3*DATA_W + 1 + 7) / 8) * 8;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   typedef struct packed {
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] d;
      logic signed [DATA_W-1:0] amount;
   } coeff_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Z = 3'd1,
      CSR_RADIUS   = 3'd2,
      CSR_COEFF_A  = 3'd3,
      CSR_COEFF_B  = 3'd4,
      CSR_COEFF_C  = 3'd5,
      CSR_COEFF_D  = 3'd6,
      CSR_AMOUNT   = 3'd7
   } csr_idx_type;

   // True when a wide signed value does not fit in DATA_W bits.
   function automatic logic ovf_s32(input logic signed [SAT_W-1:0] v);
      return !(v[SAT_W-1:DATA_W-1] == '0 || v[SAT_W-1:DATA_W-1] == '1);
   endfunction

   // Clip a wide signed value to the DATA_W signed range.
   function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (!ovf_s32(v)) begin
         r = v[DATA_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[hdl/rfho_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rfho_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_v,
   input  wire logic [rfho_pkg::RAD_SQ_W-1:0]   in_rad,
   input  wire rfho_pkg::point_type             in_pt,
   output logic                                 out_v,
   output logic [rfho_pkg::ROOT_W-1:0]          out_root,
   output rfho_pkg::point_type                  out_pt
);
   localparam int N = rfho_pkg::ROOT_W;

   logic                              v_ff    [N];
   logic [rfho_pkg::RAD_SQ_W-1:0]     rad_ff  [N];
   logic [rfho_pkg::ROOT_W-1:0]       root_ff [N];
   logic [rfho_pkg::REM_SQ_W-1:0]     rem_ff  [N];
   rfho_pkg::point_type               pt_ff   [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                           prv_v;
      logic [rfho_pkg::RAD_SQ_W-1:0]  prv_rad;
      logic [rfho_pkg::ROOT_W-1:0]    prv_root;
      logic [rfho_pkg::REM_SQ_W-1:0]  prv_rem;
      rfho_pkg::point_type            prv_pt;
      logic [rfho_pkg::REM_SQ_W-1:0]  rem_sh;
      logic [rfho_pkg::REM_SQ_W-1:0]  trial;
      logic                           fit;

      if (i == 0) begin : g_first
         assign prv_v    = in_v;
         assign prv_rad  = in_rad;
         assign prv_root = '0;
         assign prv_rem  = '0;
         assign prv_pt   = in_pt;
      end else begin : g_next
         assign prv_v    = v_ff[i-1];
         assign prv_rad  = rad_ff[i-1];
         assign prv_root = root_ff[i-1];
         assign prv_rem  = rem_ff[i-1];
         assign prv_pt   = pt_ff[i-1];
      end

      // bring down the next two radicand bits and try the next root bit
      assign rem_sh = {prv_rem[rfho_pkg::REM_SQ_W-3:0], prv_rad[rfho_pkg::RAD_SQ_W-1 -: 2]};
      assign trial  = {prv_root, 2'b01};
      assign fit    = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= prv_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= prv_rad << 2;
            root_ff[i] <= {prv_root[rfho_pkg::ROOT_W-2:0], fit};
            rem_ff[i]  <= fit ? (rem_sh - trial) : rem_sh;
            pt_ff[i]   <= prv_pt;
         end
      end
   end

   assign out_v    = v_ff[N-1];
   assign out_root = root_ff[N-1];
   assign out_pt   = pt_ff[N-1];
endmodule
`default_nettype wire

[hdl/rfho_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rfho_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic [rfho_pkg::RADIUS_W-1:0] divisor,
   input  wire logic                          in_v,
   input  wire logic [rfho_pkg::DVD_W-1:0]    in_dvd,
   input  wire rfho_pkg::point_type           in_pt,
   output logic                               out_v,
   output logic [rfho_pkg::DVD_W-1:0]         out_quo,
   output rfho_pkg::point_type                out_pt
);
   localparam int N = rfho_pkg::DVD_W;

   logic                              v_ff   [N];
   logic [rfho_pkg::DVD_W-1:0]        dvd_ff [N];
   logic [rfho_pkg::REM_DV_W-1:0]     rem_ff [N];
   rfho_pkg::point_type               pt_ff  [N];
   logic [rfho_pkg::REM_DV_W-1:0]     div_ext;

   assign div_ext = {1'b0, divisor};

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                           prv_v;
      logic [rfho_pkg::DVD_W-1:0]     prv_dvd;
      logic [rfho_pkg::REM_DV_W-1:0]  prv_rem;
      rfho_pkg::point_type            prv_pt;
      logic [rfho_pkg::REM_DV_W-1:0]  rem_sh;
      logic                           fit;

      if (i == 0) begin : g_first
         assign prv_v   = in_v;
         assign prv_dvd = in_dvd;
         assign prv_rem = '0;
         assign prv_pt  = in_pt;
      end else begin : g_next
         assign prv_v   = v_ff[i-1];
         assign prv_dvd = dvd_ff[i-1];
         assign prv_rem = rem_ff[i-1];
         assign prv_pt  = pt_ff[i-1];
      end

      // shift in the next dividend bit; the quotient fills in from the bottom
      assign rem_sh = {prv_rem[rfho_pkg::RADIUS_W-1:0], prv_dvd[rfho_pkg::DVD_W-1]};
      assign fit    = (rem_sh >= div_ext);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= prv_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[i] <= {prv_dvd[rfho_pkg::DVD_W-2:0], fit};
            rem_ff[i] <= fit ? (rem_sh - div_ext) : rem_sh;
            pt_ff[i]  <= prv_pt;
         end
      end
   end

   assign out_v   = v_ff[N-1];
   assign out_quo = dvd_ff[N-1];
   assign out_pt  = pt_ff[N-1];
endmodule
`default_nettype wire

[hdl/rfho_poly.sv]
// Falloff parameter, cubic polynomial and saturating height update pipeline.
`default_nettype none
module rfho_poly (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire rfho_pkg::coeff_type        coeff,
   input  wire logic                       in_v,
   input  wire logic [rfho_pkg::DVD_W-1:0] in_quo,
   input  wire rfho_pkg::point_type        in_pt,
   output logic                            out_v,
   output rfho_pkg::point_type             out_pt,
   output logic                            out_sat
);
   localparam int D  = rfho_pkg::POLY_DEPTH;
   localparam int F  = rfho_pkg::FRAC_BITS;
   localparam int M  = rfho_pkg::MAG_W;
   localparam int W  = rfho_pkg::DATA_W;
   localparam int SW = rfho_pkg::SAT_W;
   localparam logic [rfho_pkg::DVD_W-1:0] ONE = rfho_pkg::DVD_W'(1) << F;

   logic                 v_ff  [D];
   rfho_pkg::point_type  pt_ff [D-1];

   logic [M-1:0]           u_ff, u_in, u2_u_ff, u3_u_ff, u4_u_ff, u5_u_ff;
   logic [2*M-1:0]         uu_ff;
   logic [M-1:0]           u2_ff, u2_in, u4_u2_ff, u5_u2_ff;
   logic [2*M-1:0]         uuu_ff;
   logic [M-1:0]           u3_ff, u3_in;
   logic signed [2*W-1:0]  pb_ff, pc_ff, pd_ff;
   logic signed [W-1:0]    tb_ff, tc_ff, td_ff;
   logic [W-1:0]           poly_ff, poly_in;
   logic signed [W+1:0]    psum;
   logic signed [W-1:0]    psat;
   logic signed [2*W:0]    ph_ff;
   logic signed [2*W:0]    h;
   logic signed [SW-1:0]   ynew;
   logic [rfho_pkg::DVD_W-1:0] qdiff;
   rfho_pkg::point_type    out_pt_ff;
   logic                   out_sat_ff;

   // |t| from the quotient, clipped to the magnitude range
   always_comb begin
      qdiff = '0;
      if (in_quo <= ONE) begin
         u_in = M'(ONE - in_quo);
      end else begin
         qdiff = in_quo - ONE;
         u_in  = (qdiff > rfho_pkg::DVD_W'(rfho_pkg::MAG_MAX)) ? rfho_pkg::MAG_MAX
                                                              : qdiff[M-1:0];
      end
   end

   // rescale the powers and clip them to the magnitude range
   always_comb begin
      u2_in = (uu_ff[2*M-1:M+F] != '0) ? rfho_pkg::MAG_MAX : uu_ff[M+F-1:F];
      u3_in = (uuu_ff[2*M-1:M+F] != '0) ? rfho_pkg::MAG_MAX : uuu_ff[M+F-1:F];
   end

   // sum the terms, clip and take the magnitude
   always_comb begin
      psum    = (W+2)'(coeff.a) + (W+2)'(tb_ff) + (W+2)'(tc_ff) + (W+2)'(td_ff);
      psat    = rfho_pkg::sat_s32(SW'(psum));
      poly_in = psat[W-1] ? W'(-psat) : psat;
   end

   // add the scaled offset to the height
   always_comb begin
      h    = ph_ff >>> F;
      ynew = SW'(pt_ff[D-2].y) + SW'(h);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_v;
         for (int i = 1; i < D; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff[0] <= in_pt;
         for (int i = 1; i < D-1; i++) begin
            pt_ff[i] <= pt_ff[i-1];
         end
         u_ff     <= u_in;
         uu_ff    <= u_ff * u_ff;
         u2_u_ff  <= u_ff;
         u2_ff    <= u2_in;
         u3_u_ff  <= u2_u_ff;
         uuu_ff   <= u2_ff * u3_u_ff;
         u4_u_ff  <= u3_u_ff;
         u4_u2_ff <= u2_ff;
         u3_ff    <= u3_in;
         u5_u_ff  <= u4_u_ff;
         u5_u2_ff <= u4_u2_ff;
         pb_ff    <= coeff.b * $signed({1'b0, u5_u_ff});
         pc_ff    <= coeff.c * $signed({1'b0, u5_u2_ff});
         pd_ff    <= coeff.d * $signed({1'b0, u3_ff});
         tb_ff    <= rfho_pkg::sat_s32(SW'(pb_ff >>> F));
         tc_ff    <= rfho_pkg::sat_s32(SW'(pc_ff >>> F));
         td_ff    <= rfho_pkg::sat_s32(SW'(pd_ff >>> F));
         poly_ff  <= poly_in;
         ph_ff    <= $signed({1'b0, poly_ff}) * coeff.amount;
         out_pt_ff.x <= pt_ff[D-2].x;
         out_pt_ff.z <= pt_ff[D-2].z;
         out_pt_ff.y <= rfho_pkg::sat_s32(ynew);
         out_sat_ff  <= rfho_pkg::ovf_s32(ynew);
      end
   end

   assign out_v   = v_ff[D-1];
   assign out_pt  = out_pt_ff;
   assign out_sat = out_sat_ff;
endmodule
`default_nettype wire

[hdl/radial_falloff_height_offset.sv]
// Top level of the radial falloff height offset block.
// Usage:
//   Requests arrive on req_ (tvalid/tready/tdata) as one vertex x, y, z each.
//   Results leave on rsp_ as the vertex with y raised by |p(t)|*amount and a
//   flag that marks a clipped height. x and z pass unchanged. Configuration
//   registers are written over csr_ (write enable, index, data), by the user only
//   while no request is in flight (not enforced); a write takes effect next cycle.
// Pipeline stages and throughput:
//   An accepted request passes 3 stages for the squared distance, 33 for the
//   square root (one root bit per stage), 49 for the division by the radius
//   (one quotient bit per stage) and 10 for the polynomial and height update
//   before it shows on rsp_. One request is taken every cycle unless rsp_ stalls.
// Reset:
//   Synchronous reset empties the pipeline and sets the registers to their
//   defaults (radius 1.0, all others 0).
// Stalls:
//   While rsp_tready is low and a result waits, the whole pipeline holds. One
//   more request is caught in an input skid register, then req_tready drops.
`default_nettype none
module radial_falloff_height_offset (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [rfho_pkg::REQ_W-1:0]     req_tdata,   // point_x, point_y, point_z
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [rfho_pkg::RSP_W-1:0]          rsp_tdata,   // out_x, out_y, out_z, saturated
   input  wire logic                           csr_we,
   input  wire logic [rfho_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rfho_pkg::DATA_W-1:0]    csr_wdata
);
   localparam int W = rfho_pkg::DATA_W;

   logic signed [W-1:0]              center_x_ff, center_z_ff;
   logic [rfho_pkg::RADIUS_W-1:0]    radius_ff;
   rfho_pkg::coeff_type              coeff_ff;
   logic [rfho_pkg::RADIUS_W-1:0]    divisor;

   logic                 en;
   logic                 skid_v_ff, skid_v_in;
   rfho_pkg::point_type  skid_pt_ff;
   logic                 front_v;
   rfho_pkg::point_type  front_pt;

   logic signed [W:0]    dx, dz;
   logic [W-1:0]         ax_in, az_in, ax_ff, az_ff;
   logic [2*W-1:0]       sx_ff, sz_ff;
   logic [rfho_pkg::SUM_W-1:0] sum_ff;
   logic                 s1_v_ff, s2_v_ff, s3_v_ff;
   rfho_pkg::point_type  s1_pt_ff, s2_pt_ff, s3_pt_ff;

   logic                 sq_v, dv_v, pl_v, pl_sat;
   logic [rfho_pkg::ROOT_W-1:0] root_dist;
   logic [rfho_pkg::DVD_W-1:0]  quo;
   rfho_pkg::point_type  sq_pt, dv_pt, pl_pt;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= rfho_pkg::RADIUS_W'(1) << rfho_pkg::FRAC_BITS;
         coeff_ff    <= '0;
      end else if (csr_we) begin
         case (rfho_pkg::csr_idx_type'(csr_index))
            rfho_pkg::CSR_CENTER_X: center_x_ff  <= csr_wdata;
            rfho_pkg::CSR_CENTER_Z: center_z_ff  <= csr_wdata;
            rfho_pkg::CSR_RADIUS:   radius_ff    <= csr_wdata[rfho_pkg::RADIUS_W-1:0];
            rfho_pkg::CSR_COEFF_A:  coeff_ff.a   <= csr_wdata;
            rfho_pkg::CSR_COEFF_B:  coeff_ff.b   <= csr_wdata;
            rfho_pkg::CSR_COEFF_C:  coeff_ff.c   <= csr_wdata;
            rfho_pkg::CSR_COEFF_D:  coeff_ff.d   <= csr_wdata;
            rfho_pkg::CSR_AMOUNT:   coeff_ff.amount <= csr_wdata;
            default: ;
         endcase
      end
   end

   // treat a zero radius as a raw value of one
   assign divisor = (radius_ff == '0) ? rfho_pkg::RADIUS_W'(1) : radius_ff;

   // advance the pipeline unless a result waits at the output
   assign en = !rsp_tvalid || rsp_tready;

   // input skid: catch one request while the pipeline holds
   assign req_tready = !skid_v_ff;
   assign front_v    = skid_v_ff || req_tvalid;
   assign front_pt   = skid_v_ff ? skid_pt_ff : rfho_pkg::point_type'(req_tdata);
   assign skid_v_in  = skid_v_ff ? !en : (req_tvalid && !en);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_pt_ff <= req_tdata;
      end
   end

   // distances to the center
   always_comb begin
      dx    = (W+1)'(front_pt.x) - (W+1)'(center_x_ff);
      dz    = (W+1)'(front_pt.z) - (W+1)'(center_z_ff);
      ax_in = dx[W] ? W'(-dx) : dx[W-1:0];
      az_in = dz[W] ? W'(-dz) : dz[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= front_v;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // square and sum the distances
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff    <= ax_in;
         az_ff    <= az_in;
         s1_pt_ff <= front_pt;
         sx_ff    <= ax_ff * ax_ff;
         sz_ff    <= az_ff * az_ff;
         s2_pt_ff <= s1_pt_ff;
         sum_ff   <= {1'b0, sx_ff} + {1'b0, sz_ff};
         s3_pt_ff <= s2_pt_ff;
      end
   end

   rfho_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_v     (s3_v_ff),
      .in_rad   ({{(rfho_pkg::RAD_SQ_W-rfho_pkg::SUM_W){1'b0}}, sum_ff}),
      .in_pt    (s3_pt_ff),
      .out_v    (sq_v),
      .out_root (root_dist),
      .out_pt   (sq_pt)
   );

   rfho_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .divisor (divisor),
      .in_v    (sq_v),
      .in_dvd  ({root_dist, {rfho_pkg::FRAC_BITS{1'b0}}}),
      .in_pt   (sq_pt),
      .out_v   (dv_v),
      .out_quo (quo),
      .out_pt  (dv_pt)
   );

   rfho_poly u_poly (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .coeff   (coeff_ff),
      .in_v    (dv_v),
      .in_quo  (quo),
      .in_pt   (dv_pt),
      .out_v   (pl_v),
      .out_pt  (pl_pt),
      .out_sat (pl_sat)
   );

   // drive the response
   assign rsp_tvalid = pl_v;
   assign rsp_tdata  = {{(rfho_pkg::RSP_W-3*W-1){1'b0}}, pl_sat, pl_pt.z, pl_pt.y, pl_pt.x};
endmodule
`default_nettype wire

[hdl/rfho_chk.sv]
// Port checker for the radial falloff height offset block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rfho_chk (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [rfho_pkg::RSP_W-1:0]     rsp_tdata
);
   localparam int W = rfho_pkg::DATA_W;
   logic [W-1:0] out_y;
   logic         sat;

   assign out_y = rsp_tdata[2*W-1:W];
   assign sat   = rsp_tdata[3*W];

   // reset empties the output
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid)
   // a stalled response holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // a request taken during a stall fills the skid and drops ready
   `ASSERT_CLK_RST(a_skid_full, clock, reset, req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> !req_tready)
   // a clipped height sits at a range end
   `ASSERT_CLK_RST(a_sat_end, clock, reset, rsp_tvalid && sat |-> out_y == {1'b0, {(W-1){1'b1}}} || out_y == {1'b1, {(W-1){1'b0}}})
endmodule

bind radial_falloff_height_offset rfho_chk u_chk (.*);
`default_nettype wire

[bench/rfho_checker.sv]
// Result checker of the radial falloff height offset block: predicts and compares each vertex.
`default_nettype none
module rfho_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [rfho_pkg::REQ_W-1:0]     req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [rfho_pkg::RSP_W-1:0]     rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [rfho_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rfho_pkg::DATA_W-1:0]    csr_wdata,
   output int                                  error_count,
   output int                                  pending_count
);
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        sat;
   } vertex_type;

   longint cen_x, cen_z, rad, k_a, k_b, k_c, k_d, k_amt;
   vertex_type raised_q[$];

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Fixed-point product, floored by the arithmetic shift and clipped to 32 bits.
   function automatic longint qmul(input longint a, input longint b);
      return clip32((a * b) >>> rfho_pkg::FRAC_BITS);
   endfunction

   // Floor square root of a 65-bit sum, one root bit at a time.
   function automatic longint root_floor(input logic [64:0] n);
      logic [65:0] res;
      logic [65:0] bitv;
      logic [65:0] rem;
      res = 0;
      rem = {1'b0, n};
      bitv = 66'd1 << 64;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic vertex_type raise_vertex(input logic [rfho_pkg::REQ_W-1:0] d);
      vertex_type v;
      longint px, py, pz, dx, dz, root_val, r, q, t, u, u2, u3, p, h, y;
      logic [64:0] sum;
      px = longint'(signed'(d[31:0]));
      py = longint'(signed'(d[63:32]));
      pz = longint'(signed'(d[95:64]));
      dx = px - cen_x;
      dz = pz - cen_z;
      if (dx < 0) dx = -dx;
      if (dz < 0) dz = -dz;
      // squares can exceed 2^63, so keep them unsigned
      sum = {1'b0, dx * dx} + {1'b0, dz * dz};
      root_val = root_floor(sum);
      r = (rad == 0) ? 1 : rad;
      q = (root_val << rfho_pkg::FRAC_BITS) / r;
      t = (64'sd1 <<< rfho_pkg::FRAC_BITS) - q;
      u = (t < 0) ? -t : t;
      if (u > 64'sd2147483647) u = 64'sd2147483647;
      u2 = qmul(u, u);
      u3 = qmul(u2, u);
      p = clip32(k_a + qmul(k_b, u) + qmul(k_c, u2) + qmul(k_d, u3));
      if (p < 0) p = -p;
      h = (p * k_amt) >>> rfho_pkg::FRAC_BITS;
      y = py + h;
      v.sat = (y != clip32(y));
      v.x = d[31:0];
      v.y = clip32(y);
      v.z = d[95:64];
      return v;
   endfunction

   assign pending_count = raised_q.size();

   // Track registers, queue predictions, compare results.
   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         cen_x = 0; cen_z = 0; rad = 65536;
         k_a = 0; k_b = 0; k_c = 0; k_d = 0; k_amt = 0;
         raised_q.delete();
         error_count <= 0;
      end else begin
         if (req_tvalid && req_tready) raised_q.push_back(raise_vertex(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (raised_q.size() == 0) begin
               if (error_count < 10) $display("unexpected result %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               e = raised_q.pop_front();
               if (rsp_tdata[31:0] !== e.x || rsp_tdata[63:32] !== e.y ||
                   rsp_tdata[95:64] !== e.z || rsp_tdata[96] !== e.sat) begin
                  if (error_count < 10)
                     $display("mismatch: exp x=%h y=%h z=%h s=%b got x=%h y=%h z=%h s=%b",
                        e.x, e.y, e.z, e.sat, rsp_tdata[31:0], rsp_tdata[63:32],
                        rsp_tdata[95:64], rsp_tdata[96]);
                  error_count <= error_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (rfho_pkg::csr_idx_type'(csr_index))
               rfho_pkg::CSR_CENTER_X: cen_x = longint'(signed'(csr_wdata));
               rfho_pkg::CSR_CENTER_Z: cen_z = longint'(signed'(csr_wdata));
               rfho_pkg::CSR_RADIUS:   rad = longint'(csr_wdata[30:0]);
               rfho_pkg::CSR_COEFF_A:  k_a = longint'(signed'(csr_wdata));
               rfho_pkg::CSR_COEFF_B:  k_b = longint'(signed'(csr_wdata));
               rfho_pkg::CSR_COEFF_C:  k_c = longint'(signed'(csr_wdata));
               rfho_pkg::CSR_COEFF_D:  k_d = longint'(signed'(csr_wdata));
               rfho_pkg::CSR_AMOUNT:   k_amt = longint'(signed'(csr_wdata));
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

[bench/tb_radial_falloff_height_offset.sv]
// Stimulus and verdict for the radial falloff height offset block.
`default_nettype none
module tb_radial_falloff_height_offset;
   localparam int PIPE_LAT = 95;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rfho_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rfho_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [rfho_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rfho_pkg::DATA_W-1:0] csr_wdata = '0;
   int error_count, pending_count;
   int cycle_count = 0;
   bit long_hold = 1'b0;
   bit drain_gaps = 1'b1;

   always #4 clock = ~clock;

   radial_falloff_height_offset dut (.*);

   rfho_checker u_checker (.*);

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Accept results with random stalls; hold off for a long stretch on request.
   always @(posedge clock) begin
      int wait_n;
      if (!reset) begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_n = drain_gaps ? $urandom_range(0, 15) : 0;
         if (wait_n > 0 && $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Leave the write enable high; the caller drops it after the last write.
   task automatic write_reg(input rfho_pkg::csr_idx_type idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Wait until every expected vertex is back, then let the pipe settle.
   task automatic drain_all();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit gaps);
      int gap;
      gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 | ($urandom_range(0, 3));
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   // Small coefficient set, sometimes extreme.
   function automatic logic [31:0] rand_coeff();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      endcase
   endfunction

   task automatic random_settings(input int phase);
      write_reg(rfho_pkg::CSR_CENTER_X, (phase % 4 == 0) ? 32'h8000_0000 : rand_word());
      write_reg(rfho_pkg::CSR_CENTER_Z, (phase % 4 == 1) ? 32'h7FFF_FFFF : rand_word());
      case (phase % 5)
         0: write_reg(rfho_pkg::CSR_RADIUS, 32'd0);
         1: write_reg(rfho_pkg::CSR_RADIUS, 32'd1);
         2: write_reg(rfho_pkg::CSR_RADIUS, 32'h7FFF_FFFF);
         3: write_reg(rfho_pkg::CSR_RADIUS, $urandom);
         default: write_reg(rfho_pkg::CSR_RADIUS, $urandom_range(1 << 14, 8 << 16));
      endcase
      write_reg(rfho_pkg::CSR_COEFF_A, rand_coeff());
      write_reg(rfho_pkg::CSR_COEFF_B, rand_coeff());
      write_reg(rfho_pkg::CSR_COEFF_C, rand_coeff());
      write_reg(rfho_pkg::CSR_COEFF_D, rand_coeff());
      write_reg(rfho_pkg::CSR_AMOUNT, rand_coeff());
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, then smooth brush with extremes.
      send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      req_tvalid <= 1'b0;
      drain_all();
      write_reg(rfho_pkg::CSR_RADIUS, 32'h0004_0000);
      write_reg(rfho_pkg::CSR_COEFF_A, 32'h0001_0000);
      write_reg(rfho_pkg::CSR_COEFF_B, 32'hFFFF_0000);
      write_reg(rfho_pkg::CSR_COEFF_C, 32'h0000_8000);
      write_reg(rfho_pkg::CSR_COEFF_D, 32'h0002_0000);
      write_reg(rfho_pkg::CSR_AMOUNT, 32'h7FFF_FFFF);
      csr_we <= 1'b0;
      // Centre, on the rim, outside the radius, and y overflow upward.
      send_vertex(32'h0, 32'h7FFF_0000, 32'h0, 1'b0);
      send_vertex(32'h0004_0000, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h0010_0000, 32'h0, 32'h0010_0000, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      req_tvalid <= 1'b0;
      drain_all();
      write_reg(rfho_pkg::CSR_AMOUNT, 32'h8000_0000);
      write_reg(rfho_pkg::CSR_CENTER_X, 32'h7FFF_FFFF);
      write_reg(rfho_pkg::CSR_CENTER_Z, 32'h8000_0000);
      csr_we <= 1'b0;
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_vertex(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
      req_tvalid <= 1'b0;
      drain_all();

      // Random phases; pressure on phase 2 and a full pause midway through phase 4.
      for (int phase = 0; phase < 10; phase++) begin
         random_settings(phase);
         if (phase == 2) long_hold = 1'b1;
         drain_gaps = (phase % 3 != 1);
         for (int i = 0; i < 165; i++) begin
            send_vertex(rand_word(), rand_word(), rand_word(),
                        drain_gaps && phase != 2);
            if (phase == 4 && i == 80) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
         end
         req_tvalid <= 1'b0;
         drain_all();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

[radial_falloff_height_offset.f]
+incdir+hdl
hdl/rfho_pkg.sv
hdl/rfho_sqrt.sv
hdl/rfho_div.sv
hdl/rfho_poly.sv
hdl/radial_falloff_height_offset.sv
hdl/rfho_chk.sv
bench/rfho_checker.sv
bench/tb_radial_falloff_height_offset.sv
